// ===== src/bhi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bhi_pkg;

	// Default geometry of the position and time formats.
	localparam int DEF_POS_WIDTH   = 24;
	localparam int DEF_T_FRAC_BITS = 16;

	// Fixed field widths.
	localparam int TICK_W     = 20;
	localparam int DUR_W      = 24;
	localparam int PITCH_W    = 10;
	localparam int ELAPSED_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int EV_W       = 2;
	localparam int DIR_W      = 2;
	localparam int STEP_CNT_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_TIME    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOP_DURATION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_X      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Y      = 2'd3;

	// Configuration values after reset.
	localparam logic [TICK_W-1:0]  RST_TICK_TIME    = 20'd16667;
	localparam logic [DUR_W-1:0]   RST_HOP_DURATION = 24'd500000;
	localparam logic [PITCH_W-1:0] RST_PITCH_X      = 10'd32;
	localparam logic [PITCH_W-1:0] RST_PITCH_Y      = 10'd48;

	// Event codes of a result transaction.
	localparam logic [EV_W-1:0] EV_UPDATE = 2'd0;
	localparam logic [EV_W-1:0] EV_START  = 2'd1;
	localparam logic [EV_W-1:0] EV_FINISH = 2'd2;

	// Action codes of an input transaction.
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_HOP  = 1'b1;

	// Two-bit signed direction codes.
	localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
	localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
	localparam logic [DIR_W-1:0] DIR_NEG2 = 2'b10;
	localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

	// Last of the six lerp steps of one de Casteljau pass.
	localparam logic [STEP_CNT_W-1:0] STEP_LAST = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            start_hop;
		logic            tick_add;
		logic            finish;
		logic            load_pts;
		logic            t_one;
		logic            div_init;
		logic            div_step;
		logic            lerp_mul;
		logic            lerp_add;
		logic [1:0]      lerp_idx;
		logic            lerp_axis;
		logic            commit;
		logic            out_load;
		logic [EV_W-1:0] out_ev;
	} bhi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hopping;
		logic at_target;
		logic t_full;
	} bhi_status_t;

	// The in-place de Casteljau order: points 0,1,2 then 0,1 then 0.
	function automatic logic [1:0] lerp_index(input logic [STEP_CNT_W-1:0] step);
		logic [1:0] idx;
		unique case (step)
			3'd0: idx = 2'd0;
			3'd1: idx = 2'd1;
			3'd2: idx = 2'd2;
			3'd3: idx = 2'd0;
			3'd4: idx = 2'd1;
			default: idx = 2'd0;
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== src/bhi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhi_ctrl
	import bhi_pkg::*;
#(
	parameter int T_FRAC_BITS = DEF_T_FRAC_BITS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         action,
	output logic        out_valid,
	input  wire         out_stall,
	input  bhi_status_t status,
	output bhi_cmd_t    cmd
);

	localparam int DCW = $clog2(T_FRAC_BITS);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(T_FRAC_BITS - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DINIT  = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_LMUL   = 3'd3;
	localparam logic [2:0] ST_LADD   = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0]            state_q, state_d;
	logic [EV_W-1:0]       ev_q, ev_d;
	logic [STEP_CNT_W-1:0] step_q, step_d;
	logic                  axis_q, axis_d;
	logic [DCW-1:0]        cnt_q, cnt_d;
	logic                  outv_q, outv_d;

	// Input transactions are taken only while no item is in work.
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = outv_q;

	// Sequencer for one item.
	always_comb begin
		cmd           = '0;
		cmd.lerp_idx  = lerp_index(step_q);
		cmd.lerp_axis = axis_q;
		cmd.out_ev    = ev_q;
		state_d       = state_q;
		ev_d          = ev_q;
		step_d        = step_q;
		axis_d        = axis_q;
		cnt_d         = cnt_q;
		outv_d        = outv_q & out_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (action == ACT_HOP) begin
						cmd.start_hop = 1'b1;
						ev_d          = EV_START;
						state_d       = ST_EMIT;
					end else if (!status.hopping) begin
						state_d = ST_IDLE;
					end else if (status.at_target) begin
						cmd.finish = 1'b1;
						ev_d       = EV_FINISH;
						state_d    = ST_EMIT;
					end else begin
						cmd.tick_add = 1'b1;
						state_d      = ST_DINIT;
					end
				end
			end
			ST_DINIT: begin
				cmd.load_pts = 1'b1;
				step_d       = '0;
				axis_d       = 1'b0;
				cnt_d        = '0;
				if (status.t_full) begin
					cmd.t_one = 1'b1;
					state_d   = ST_LMUL;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_LMUL;
				end
			end
			ST_LMUL: begin
				cmd.lerp_mul = 1'b1;
				state_d      = ST_LADD;
			end
			ST_LADD: begin
				cmd.lerp_add = 1'b1;
				if (step_q == STEP_LAST) begin
					step_d = '0;
					if (axis_q) begin
						state_d = ST_COMMIT;
					end else begin
						axis_d  = 1'b1;
						state_d = ST_LMUL;
					end
				end else begin
					step_d  = step_q + 1'b1;
					state_d = ST_LMUL;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				ev_d       = EV_UPDATE;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (!outv_q || !out_stall) begin
					cmd.out_load = 1'b1;
					outv_d       = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ev_q    <= EV_UPDATE;
			step_q  <= '0;
			axis_q  <= 1'b0;
			cnt_q   <= '0;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ev_q    <= ev_d;
			step_q  <= step_d;
			axis_q  <= axis_d;
			cnt_q   <= cnt_d;
			outv_q  <= outv_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/bhi_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhi_dpath
	import bhi_pkg::*;
#(
	parameter int POS_WIDTH   = DEF_POS_WIDTH,
	parameter int T_FRAC_BITS = DEF_T_FRAC_BITS
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  bhi_cmd_t                    cmd,
	output bhi_status_t                 status,
	input  wire                         cfg_we,
	input  wire [CFG_IDX_W-1:0]         cfg_index,
	input  wire [CFG_DATA_W-1:0]        cfg_data,
	input  wire signed [DIR_W-1:0]      row_step,
	input  wire signed [DIR_W-1:0]      col_step,
	input  wire signed [POS_WIDTH-1:0]  origin_x,
	input  wire signed [POS_WIDTH-1:0]  origin_y,
	output logic signed [POS_WIDTH-1:0] pos_x,
	output logic signed [POS_WIDTH-1:0] pos_y,
	output logic [EV_W-1:0]             event_res
);

	// Control points are kept at twice their value.
	localparam int PW  = POS_WIDTH + 1;
	localparam int DW  = PW + 1;
	localparam int PRW = DW + T_FRAC_BITS + 2;
	// Wide enough for a position plus a full pitch offset.
	localparam int SW  = ((POS_WIDTH > 19) ? POS_WIDTH : 19) + 1;
	localparam int RW  = DUR_W + 1;

	localparam logic signed [SW-1:0] MAXW =
		{{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
	localparam logic signed [SW-1:0] MINW = ~MAXW;
	localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (T_FRAC_BITS - 1);

	function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [SW-1:0] v);
		logic signed [POS_WIDTH-1:0] r;
		if (v > MAXW) begin
			r = {1'b0, {(POS_WIDTH - 1){1'b1}}};
		end else if (v < MINW) begin
			r = {1'b1, {(POS_WIDTH - 1){1'b0}}};
		end else begin
			r = v[POS_WIDTH-1:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic [TICK_W-1:0]  tick_time_q;
	logic [DUR_W-1:0]   hop_dur_q;
	logic [PITCH_W-1:0] pitch_x_q;
	logic [PITCH_W-1:0] pitch_y_q;

	// Hop state.
	logic                        hopping_q;
	logic [ELAPSED_W-1:0]        elapsed_q;
	logic [DIR_W-1:0]            vdir_q;
	logic signed [POS_WIDTH-1:0] begin_x_q, begin_y_q;
	logic signed [POS_WIDTH-1:0] target_x_q, target_y_q;
	logic signed [POS_WIDTH-1:0] cur_x_q, cur_y_q;

	// Divider, interpolation parameter and control points.
	logic [RW-1:0]          rem_q;
	logic [T_FRAC_BITS:0]   t_q;
	logic signed [PW-1:0]   ptx_q [4];
	logic signed [PW-1:0]   pty_q [4];
	logic signed [PRW-1:0]  prod_s1;
	logic signed [PW-1:0]   lo_s1;

	assign status.hopping   = hopping_q;
	assign status.at_target = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
	assign status.t_full    = (hop_dur_q == '0) || (elapsed_q >= ELAPSED_W'(hop_dur_q));

	// Direction clean-up: a step of minus two counts as minus one, and a zero column
	// leans away from the row direction.
	logic [DIR_W-1:0] row_c, col_t, col_c;
	always_comb begin
		row_c = (row_step == DIR_NEG2) ? DIR_NEG : row_step;
		col_t = (col_step == DIR_NEG2) ? DIR_NEG : col_step;
		col_c = col_t;
		if (col_t == DIR_ZERO && row_c == DIR_POS) begin
			col_c = DIR_NEG;
		end else if (col_t == DIR_ZERO && row_c == DIR_NEG) begin
			col_c = DIR_POS;
		end
	end

	// End point of a new hop.
	logic signed [SW-1:0] off_x, off_y, org_xw, org_yw, sum_x, sum_y;
	always_comb begin
		off_x  = $signed(SW'({pitch_x_q, 8'b0}));
		off_y  = $signed(SW'({pitch_y_q, 8'b0}));
		org_xw = SW'(origin_x);
		org_yw = SW'(origin_y);
		unique case (col_c)
			DIR_POS: sum_x = org_xw + off_x;
			DIR_NEG: sum_x = org_xw - off_x;
			default: sum_x = org_xw;
		endcase
		unique case (row_c)
			DIR_POS: sum_y = org_yw + off_y;
			DIR_NEG: sum_y = org_yw - off_y;
			default: sum_y = org_yw;
		endcase
	end

	// Saturating elapsed-time update.
	logic [ELAPSED_W:0] el_sum;
	assign el_sum = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(tick_time_q);

	// Corner point: the start, or the end point in one coordinate.
	logic signed [POS_WIDTH-1:0] corner_x, corner_y;
	always_comb begin
		unique case (vdir_q)
			DIR_NEG: begin
				corner_x = begin_x_q;
				corner_y = target_y_q;
			end
			DIR_POS: begin
				corner_x = target_x_q;
				corner_y = begin_y_q;
			end
			default: begin
				corner_x = begin_x_q;
				corner_y = begin_y_q;
			end
		endcase
	end

	// One restoring division step.
	logic [RW-1:0] rem_sh;
	logic          rem_ge;
	assign rem_sh = {rem_q[DUR_W-1:0], 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, hop_dur_q});

	// Lerp operand selection.
	logic signed [PW-1:0] op_lo, op_hi;
	always_comb begin
		unique case (cmd.lerp_idx)
			2'd0: begin
				op_lo = cmd.lerp_axis ? pty_q[0] : ptx_q[0];
				op_hi = cmd.lerp_axis ? pty_q[1] : ptx_q[1];
			end
			2'd1: begin
				op_lo = cmd.lerp_axis ? pty_q[1] : ptx_q[1];
				op_hi = cmd.lerp_axis ? pty_q[2] : ptx_q[2];
			end
			default: begin
				op_lo = cmd.lerp_axis ? pty_q[2] : ptx_q[2];
				op_hi = cmd.lerp_axis ? pty_q[3] : ptx_q[3];
			end
		endcase
	end

	// Lerp multiply and rounding add.
	logic signed [DW-1:0]          diff;
	logic signed [T_FRAC_BITS+1:0] t_s;
	logic signed [PRW-1:0]         prod, rnd, shr;
	logic signed [PW-1:0]          lerp_res;
	always_comb begin
		diff     = DW'(op_hi) - DW'(op_lo);
		t_s      = $signed({1'b0, t_q});
		prod     = diff * t_s;
		rnd      = prod_s1 + HALF;
		shr      = rnd >>> T_FRAC_BITS;
		lerp_res = lo_s1 + shr[PW-1:0];
	end

	// Final halving with round half up.
	logic signed [PW:0]   half_x, half_y;
	logic signed [PW:0]   hv_x, hv_y;
	always_comb begin
		half_x = (PW + 1)'(ptx_q[0]) + (PW + 1)'(1);
		half_y = (PW + 1)'(pty_q[0]) + (PW + 1)'(1);
		hv_x   = half_x >>> 1;
		hv_y   = half_y >>> 1;
	end

	// Configuration and hop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_time_q <= RST_TICK_TIME;
			hop_dur_q   <= RST_HOP_DURATION;
			pitch_x_q   <= RST_PITCH_X;
			pitch_y_q   <= RST_PITCH_Y;
			hopping_q   <= 1'b0;
			elapsed_q   <= '0;
			vdir_q      <= DIR_ZERO;
			begin_x_q   <= '0;
			begin_y_q   <= '0;
			target_x_q  <= '0;
			target_y_q  <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TICK_TIME:    tick_time_q <= cfg_data[TICK_W-1:0];
					CFG_HOP_DURATION: hop_dur_q   <= cfg_data[DUR_W-1:0];
					CFG_PITCH_X:      pitch_x_q   <= cfg_data[PITCH_W-1:0];
					default:          pitch_y_q   <= cfg_data[PITCH_W-1:0];
				endcase
			end
			if (cmd.start_hop) begin
				begin_x_q  <= origin_x;
				begin_y_q  <= origin_y;
				target_x_q <= sat_pos(sum_x);
				target_y_q <= sat_pos(sum_y);
				vdir_q     <= row_c;
				hopping_q  <= 1'b1;
			end
			if (cmd.finish) begin
				hopping_q <= 1'b0;
				elapsed_q <= '0;
			end
			if (cmd.tick_add) begin
				elapsed_q <= el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
			end
			if (cmd.commit) begin
				cur_x_q <= sat_pos(SW'($signed(hv_x[PW-1:0])));
				cur_y_q <= sat_pos(SW'($signed(hv_y[PW-1:0])));
			end
		end
	end

	// Divider, control points and lerp pipeline.
	always_ff @(posedge clk) begin
		if (cmd.t_one) begin
			t_q <= {1'b1, {T_FRAC_BITS{1'b0}}};
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, elapsed_q[DUR_W-1:0]};
			t_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? (rem_sh - {1'b0, hop_dur_q}) : rem_sh;
			t_q   <= {t_q[T_FRAC_BITS-1:0], rem_ge};
		end
		if (cmd.load_pts) begin
			ptx_q[0] <= {begin_x_q, 1'b0};
			ptx_q[1] <= PW'(begin_x_q) + PW'(corner_x);
			ptx_q[2] <= PW'(target_x_q) + PW'(corner_x);
			ptx_q[3] <= {target_x_q, 1'b0};
			pty_q[0] <= {begin_y_q, 1'b0};
			pty_q[1] <= PW'(begin_y_q) + PW'(corner_y);
			pty_q[2] <= PW'(target_y_q) + PW'(corner_y);
			pty_q[3] <= {target_y_q, 1'b0};
		end
		if (cmd.lerp_mul) begin
			prod_s1 <= prod;
			lo_s1   <= op_lo;
		end
		if (cmd.lerp_add) begin
			if (cmd.lerp_axis) begin
				pty_q[cmd.lerp_idx] <= lerp_res;
			end else begin
				ptx_q[cmd.lerp_idx] <= lerp_res;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pos_x     <= (cmd.out_ev == EV_START) ? begin_x_q : cur_x_q;
			pos_y     <= (cmd.out_ev == EV_START) ? begin_y_q : cur_y_q;
			event_res <= cmd.out_ev;
		end
	end

endmodule

`default_nettype wire

// ===== src/bezier_hop_interpolator_unit.sv =====
// A hop item or a finishing tick goes from acceptance straight to the output register; a moving
// tick item first passes the bit-serial divider (skipped when t is full), then the shared lerp
// multiplier (twelve lerps) and the commit. One item is in work at a time; the next is taken
// once the result is loaded, and output stalls hold the block.
// Reset (arst_n low, asynchronous) clears all hop state and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module bezier_hop_interpolator_unit
	import bhi_pkg::*;
#(
	parameter int POS_WIDTH   = DEF_POS_WIDTH,
	parameter int T_FRAC_BITS = DEF_T_FRAC_BITS
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         action,
	input  wire signed [DIR_W-1:0]      row_step,
	input  wire signed [DIR_W-1:0]      col_step,
	input  wire signed [POS_WIDTH-1:0]  origin_x,
	input  wire signed [POS_WIDTH-1:0]  origin_y,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic signed [POS_WIDTH-1:0] pos_x,
	output logic signed [POS_WIDTH-1:0] pos_y,
	output logic [EV_W-1:0]             event_res,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [CFG_IDX_W-1:0]         cfg_index,
	input  wire [CFG_DATA_W-1:0]        cfg_data
);

	bhi_cmd_t    cmd;
	bhi_status_t status;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	bhi_ctrl #(
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bhi_dpath #(
		.POS_WIDTH   (POS_WIDTH),
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row_step  (row_step),
		.col_step  (col_step),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.event_res (event_res)
	);

endmodule

`default_nettype wire

// ===== src/bhi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bhi_checker
	import bhi_pkg::*;
#(
	parameter int POS_WIDTH = DEF_POS_WIDTH
) (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_stall,
	input wire                        action,
	input wire                        out_valid,
	input wire                        out_stall,
	input wire signed [POS_WIDTH-1:0] pos_x,
	input wire signed [POS_WIDTH-1:0] pos_y,
	input wire [EV_W-1:0]             event_res
);

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(event_res))
		else $error("stalled result changed");

	// Only the three defined event codes appear.
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res == EV_UPDATE || event_res == EV_START
			|| event_res == EV_FINISH))
		else $error("undefined event code");

	// A hop transaction keeps the input side busy while its result is formed.
	a_hop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_HOP |=> in_stall)
		else $error("input taken while a hop result is pending");

	// With a free output, a hop transaction goes through the emit state and then shows its start event.
	a_hop_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_HOP && !out_valid |=> ##1
			out_valid && event_res == EV_START)
		else $error("hop start result missing");

endmodule

bind bezier_hop_interpolator_unit bhi_checker #(
	.POS_WIDTH (POS_WIDTH)
) u_bhi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.action    (action),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pos_x     (pos_x),
	.pos_y     (pos_y),
	.event_res (event_res)
);

`default_nettype wire

// ===== sim/bezier_hop_interpolator_unit_tb.sv =====
`timescale 1ns / 1ps

module bezier_hop_interpolator_unit_tb;
	import bhi_pkg::*;

	localparam int PW = DEF_POS_WIDTH;
	localparam int T_FRAC = DEF_T_FRAC_BITS;
	localparam longint T_ONE = 64'sd1 <<< T_FRAC;
	localparam longint T_HALF = 64'sd1 <<< (T_FRAC - 1);
	localparam longint POS_MAX = (64'sd1 <<< (PW - 1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;
	localparam logic [PW-1:0] ORG_MAX = {1'b0, {(PW - 1){1'b1}}};
	localparam logic [PW-1:0] ORG_MIN = {1'b1, {(PW - 1){1'b0}}};
	localparam int SETTLE_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned RANDOM_RESULTS = 550;

	typedef struct packed {
		logic [PW-1:0]   x;
		logic [PW-1:0]   y;
		logic [EV_W-1:0] ev;
	} position_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic action = ACT_TICK;
	logic signed [DIR_W-1:0] row_step = DIR_ZERO;
	logic signed [DIR_W-1:0] col_step = DIR_ZERO;
	logic signed [PW-1:0] origin_x = '0;
	logic signed [PW-1:0] origin_y = '0;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TICK_TIME;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire in_stall;
	wire out_valid;
	wire signed [PW-1:0] pos_x;
	wire signed [PW-1:0] pos_y;
	wire [EV_W-1:0] event_res;
	wire cfg_ready;

	bezier_hop_interpolator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.row_step(row_step),
		.col_step(col_step),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.event_res(event_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the registers and the hop state.
	logic [TICK_W-1:0] cur_tick;
	logic [DUR_W-1:0] cur_dur;
	logic [PITCH_W-1:0] cur_px, cur_py;
	logic hop_active;
	logic [ELAPSED_W-1:0] hop_elapsed;
	logic [DIR_W-1:0] hop_vdir;
	longint start_x, start_y, end_x, end_y, at_x, at_y;

	position_report_t awaited_reports[$];
	int unsigned report_count = 0;
	int mismatches = 0;
	int unsigned cycles = 0;
	int pend_gap = 0;
	bit valid_held = 1'b0;
	bit idling_on = 1'b1;
	int rx_hold = 0;
	int hop_ticks = 4;

	function automatic longint clip_pos(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	// One linear interpolation on the doubled scale, rounded half up.
	function automatic longint blend(input longint a, input longint b, input longint t);
		return a + (((b - a) * t + T_HALF) >>> T_FRAC);
	endfunction

	// De Casteljau evaluation of a cubic on doubled control points.
	function automatic longint hop_curve(input longint p0, input longint p1, input longint p2,
			input longint p3, input longint t);
		longint a, b, c, d, e, f;
		a = blend(p0, p1, t);
		b = blend(p1, p2, t);
		c = blend(p2, p3, t);
		d = blend(a, b, t);
		e = blend(b, c, t);
		f = blend(d, e, t);
		return clip_pos((f + 1) >>> 1);
	endfunction

	// Most gaps are short; a few are long. No gaps while idling is off.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling_on)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [PW-1:0] pick_origin();
		case ($urandom_range(0, 7))
			0: return ORG_MAX - PW'($urandom_range(0, 300000));
			1: return ORG_MIN + PW'($urandom_range(0, 300000));
			2, 3: return PW'($urandom);
			default: return PW'(int'($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	function automatic logic [PITCH_W-1:0] pick_pitch();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			default: return PITCH_W'($urandom);
		endcase
	endfunction

	// Sets random bits above a register's width half of the time; they are ignored.
	function automatic logic [CFG_DATA_W-1:0] junk_above(input logic [CFG_DATA_W-1:0] v,
			input int w);
		logic [CFG_DATA_W-1:0] mask;
		mask = {CFG_DATA_W{1'b1}} << w;
		if ($urandom_range(0, 1) == 1)
			return v | (CFG_DATA_W'($urandom) & mask);
		return v;
	endfunction

	task automatic reset_model();
		cur_tick = RST_TICK_TIME;
		cur_dur = RST_HOP_DURATION;
		cur_px = RST_PITCH_X;
		cur_py = RST_PITCH_Y;
		hop_active = 1'b0;
		hop_elapsed = '0;
		hop_vdir = DIR_ZERO;
		start_x = 0;
		start_y = 0;
		end_x = 0;
		end_y = 0;
		at_x = 0;
		at_y = 0;
	endtask

	// Works out the result of one accepted transaction and queues it.
	task automatic predict_motion(input logic act, input logic [DIR_W-1:0] rs,
			input logic [DIR_W-1:0] cs, input logic [PW-1:0] ox, input logic [PW-1:0] oy);
		logic [DIR_W-1:0] r2, c2;
		longint r, c, kx, ky, t;
		logic [ELAPSED_W:0] sum;
		logic [63:0] num;
		position_report_t res;
		bit produced;
		produced = 1'b0;
		r2 = (rs == DIR_NEG2) ? DIR_NEG : rs;
		c2 = (cs == DIR_NEG2) ? DIR_NEG : cs;
		if (act == ACT_HOP) begin
			// A pure vertical hop still leans sideways.
			if (c2 == DIR_ZERO && r2 == DIR_POS)
				c2 = DIR_NEG;
			else if (c2 == DIR_ZERO && r2 == DIR_NEG)
				c2 = DIR_POS;
			r = $signed(r2);
			c = $signed(c2);
			start_x = $signed(ox);
			start_y = $signed(oy);
			end_x = clip_pos(start_x + c * longint'(cur_px) * 256);
			end_y = clip_pos(start_y + r * longint'(cur_py) * 256);
			hop_vdir = r2;
			hop_active = 1'b1;
			res.x = ox;
			res.y = oy;
			res.ev = EV_START;
			produced = 1'b1;
		end else if (hop_active) begin
			if (at_x != end_x || at_y != end_y) begin
				sum = {1'b0, hop_elapsed} + cur_tick;
				hop_elapsed = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
				if (cur_dur == 0 || hop_elapsed >= cur_dur) begin
					t = T_ONE;
				end else begin
					num = 64'(hop_elapsed) << T_FRAC;
					t = longint'(num / cur_dur);
				end
				// The corner pulls the inner control points; row zero uses the start.
				case (hop_vdir)
					DIR_NEG: begin
						kx = start_x;
						ky = end_y;
					end
					DIR_POS: begin
						kx = end_x;
						ky = start_y;
					end
					default: begin
						kx = start_x;
						ky = start_y;
					end
				endcase
				at_x = hop_curve(2 * start_x, start_x + kx, end_x + kx, 2 * end_x, t);
				at_y = hop_curve(2 * start_y, start_y + ky, end_y + ky, 2 * end_y, t);
				res.ev = EV_UPDATE;
			end else begin
				hop_active = 1'b0;
				hop_elapsed = '0;
				res.ev = EV_FINISH;
			end
			res.x = at_x[PW-1:0];
			res.y = at_y[PW-1:0];
			produced = 1'b1;
		end
		if (produced) begin
			awaited_reports.push_back(res);
			report_count++;
		end
	endtask

	// Sends one input transaction; valid stays high when the next one follows at once.
	task automatic send_item(input logic act, input logic [DIR_W-1:0] rs,
			input logic [DIR_W-1:0] cs, input logic [PW-1:0] ox, input logic [PW-1:0] oy);
		if (pend_gap > 0)
			repeat (pend_gap) @(posedge clk);
		in_valid <= 1'b1;
		action <= act;
		row_step <= rs;
		col_step <= cs;
		origin_x <= ox;
		origin_y <= oy;
		do @(posedge clk); while (in_stall);
		predict_motion(act, rs, cs, ox, oy);
		pend_gap = pick_gap();
		valid_held = (pend_gap == 0);
		if (!valid_held)
			in_valid <= 1'b0;
	endtask

	task automatic send_tick();
		send_item(ACT_TICK, DIR_W'($urandom), DIR_W'($urandom), PW'($urandom), PW'($urandom));
	endtask

	// Waits until every result is in and the block has had time to go idle.
	task automatic drain();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller owns cfg_valid.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TICK_TIME: cur_tick = val[TICK_W-1:0];
			CFG_HOP_DURATION: cur_dur = val[DUR_W-1:0];
			CFG_PITCH_X: cur_px = val[PITCH_W-1:0];
			CFG_PITCH_Y: cur_py = val[PITCH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] tick_v,
			input logic [CFG_DATA_W-1:0] dur_v, input logic [CFG_DATA_W-1:0] px_v,
			input logic [CFG_DATA_W-1:0] py_v);
		cfg_valid <= 1'b1;
		put_reg(CFG_TICK_TIME, tick_v);
		put_reg(CFG_HOP_DURATION, dur_v);
		put_reg(CFG_PITCH_X, px_v);
		put_reg(CFG_PITCH_Y, py_v);
		cfg_valid <= 1'b0;
	endtask

	// Picks a setting, mostly one where a hop ends within a few ticks.
	task automatic random_setup();
		logic [DUR_W-1:0] dur_v;
		logic [TICK_W-1:0] tick_v;
		longint q;
		int unsigned ratio;
		case ($urandom_range(0, 7))
			0: dur_v = '0;
			1: dur_v = 1;
			2: dur_v = '1;
			3: dur_v = DUR_W'($urandom);
			default: dur_v = DUR_W'($urandom_range(1000, 1000000));
		endcase
		ratio = $urandom_range(1, 12);
		q = longint'(dur_v) / ratio;
		if (q < 1)
			q = 1;
		if (q > longint'({TICK_W{1'b1}}))
			q = longint'({TICK_W{1'b1}});
		case ($urandom_range(0, 11))
			0: tick_v = '1;
			1: tick_v = '0;
			2: tick_v = TICK_W'($urandom);
			default: tick_v = TICK_W'(q);
		endcase
		if (tick_v == 0)
			hop_ticks = 6;
		else if (dur_v / tick_v + 2 > 18)
			hop_ticks = 18;
		else
			hop_ticks = dur_v / tick_v + 2;
		program_regs(junk_above(CFG_DATA_W'(tick_v), TICK_W), dur_v,
			junk_above(CFG_DATA_W'(pick_pitch()), PITCH_W),
			junk_above(CFG_DATA_W'(pick_pitch()), PITCH_W));
	endtask

	// Idle tick, then a vertical hop at the reset settings.
	task automatic test_power_on_defaults();
		send_tick();
		send_item(ACT_HOP, DIR_POS, DIR_ZERO, '0, '0);
		repeat (3) send_tick();
	endtask

	// Hops from the corners of the range so that the end point saturates.
	task automatic test_extreme_hops();
		drain();
		program_regs(250000, 500000, 1023, 1023);
		send_item(ACT_HOP, DIR_NEG, DIR_ZERO, ORG_MAX, ORG_MAX);
		repeat (4) send_tick();
		send_item(ACT_HOP, DIR_NEG2, DIR_NEG2, ORG_MIN, ORG_MIN);
		repeat (4) send_tick();
	endtask

	// Row zero, zero pitch, zero duration, and a new hop before the old one ends.
	task automatic test_flat_hops();
		drain();
		program_regs(24'hF00003, '0, '0, 700);
		send_item(ACT_HOP, DIR_ZERO, DIR_POS, PW'(1000), PW'(-500));
		repeat (2) send_tick();
		drain();
		program_regs(5, '1, 1023, '0);
		send_item(ACT_HOP, DIR_ZERO, DIR_NEG, pick_origin(), pick_origin());
		repeat (2) send_tick();
		send_item(ACT_HOP, DIR_POS, DIR_POS, pick_origin(), pick_origin());
		send_tick();
	endtask

	// Restarting hops keeps the time growing far past the hop duration.
	task automatic test_elapsed_saturation();
		int i;
		drain();
		idling_on = 1'b0;
		program_regs('1, '1, 5, 7);
		for (i = 0; i < 30; i++) begin
			send_item(ACT_HOP, DIR_POS, DIR_POS, (i % 2 == 1) ? PW'(25600) : '0, PW'(-3000));
			send_tick();
		end
		// The next tick finishes, so the time starts over for the last hop.
		repeat (2) send_tick();
		send_item(ACT_HOP, DIR_NEG, DIR_ZERO, '0, '0);
		repeat (2) send_tick();
		idling_on = 1'b1;
	endtask

	// Hop transactions followed by tick runs, with stray transactions mixed in.
	task automatic test_random_traffic();
		int unsigned stop_at;
		int phase, k;
		for (phase = 0; phase < 5; phase++) begin
			drain();
			random_setup();
			idling_on = (phase != 2);
			stop_at = report_count + RANDOM_RESULTS / 5;
			while (report_count < stop_at) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item($urandom_range(0, 1), DIR_W'($urandom), DIR_W'($urandom),
						pick_origin(), pick_origin());
				end else begin
					send_item(ACT_HOP, DIR_W'($urandom), DIR_W'($urandom),
						pick_origin(), pick_origin());
					k = $urandom_range(1, hop_ticks);
					repeat (k) send_tick();
				end
			end
		end
		idling_on = 1'b1;
	endtask

	// Receiver stall in runs of random length.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			out_stall <= idling_on && ($urandom_range(0, 2) == 0);
			rx_hold = pick_gap();
		end
	end

	// Each result transaction is checked against the oldest prediction.
	always @(posedge clk) begin : check_reports
		position_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_reports.size() == 0) begin
				$error("unexpected result: pos_x %0d pos_y %0d event_res %0d",
					pos_x, pos_y, event_res);
				mismatches++;
			end else begin
				want = awaited_reports.pop_front();
				if (pos_x !== want.x) begin
					$error("pos_x expected %0d, got %0d", $signed(want.x), pos_x);
					mismatches++;
				end
				if (pos_y !== want.y) begin
					$error("pos_y expected %0d, got %0d", $signed(want.y), pos_y);
					mismatches++;
				end
				if (event_res !== want.ev) begin
					$error("event_res expected %0d, got %0d", want.ev, event_res);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_defaults();
		test_extreme_hops();
		test_flat_hops();
		test_elapsed_saturation();
		test_random_traffic();
		drain();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bhi_pkg.sv
src/bhi_ctrl.sv
src/bhi_dpath.sv
src/bezier_hop_interpolator_unit.sv
src/bhi_checker.sv
sim/bezier_hop_interpolator_unit_tb.sv
